FILE: rtl/i2c_master_register_write_defines.svh
`ifndef I2C_MASTER_REGISTER_WRITE_DEFINES_SVH
`define I2C_MASTER_REGISTER_WRITE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, quiet during reset.
`define IMRW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, quiet during reset.
`define IMRW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/imrw_pkg.sv
package imrw_pkg;

    localparam logic [7:0] HALF_BIT_TICKS_RESET = 8'd5;
    localparam logic [7:0] ACK_POLL_LIMIT_RESET = 8'd20;
    localparam int         MSB_BIT              = 7;

    typedef enum logic [0:0] {
        CFG_HALF_BIT_TICKS = 1'b0,
        CFG_ACK_POLL_LIMIT = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        PH_IDLE = 4'd0,
        PH_S0   = 4'd1,
        PH_S1   = 4'd2,
        PH_S2   = 4'd3,
        PH_S3   = 4'd4,
        PH_B0   = 4'd5,
        PH_B1   = 4'd6,
        PH_B2   = 4'd7,
        PH_A0   = 4'd8,
        PH_A1   = 4'd9,
        PH_POLL = 4'd10,
        PH_AEND = 4'd11,
        PH_P0   = 4'd12,
        PH_P1   = 4'd13,
        PH_P2   = 4'd14
    } t_phase;

    typedef struct packed {
        logic       request_valid;
        logic [6:0] device_address;
        logic [7:0] register_address;
        logic [7:0] data_value;
        logic       sda_level;
    } t_item;

    typedef struct packed {
        logic       scl_level;
        logic       sda_pull_low;
        logic       busy_res;
        logic       done_res;
        logic [2:0] byte_acks;
        logic       any_ack_seen;
    } t_res;

    // Handshake between a queue and the sequencer
    typedef struct packed {
        logic avail;
        logic take;
    } t_link;

endpackage

FILE: rtl/imrw_front.sv
module imrw_front
    import imrw_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_take,
    output logic  o_avail,
    output t_item o_item
);

    t_item      r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       s_wr, s_rd;

    assign o_full  = (r_count == 2'd2);
    assign o_avail = (r_count != 2'd0);
    assign o_item  = r_mem[r_rd_ptr];
    assign s_wr    = i_push && !o_full;
    assign s_rd    = i_take && o_avail;

    always_comb begin
        n_wr_ptr = s_wr ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = s_rd ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, s_wr} - {1'b0, s_rd};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_wr) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

FILE: rtl/imrw_res_queue.sv
module imrw_res_queue
    import imrw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_put,
    input  t_res i_res,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_res o_res
);

    t_res       r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       s_wr, s_rd;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_res   = r_mem[r_rd_ptr];
    assign s_wr    = i_put && !o_full;
    assign s_rd    = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = s_wr ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = s_rd ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, s_wr} - {1'b0, s_rd};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_wr) begin
            r_mem[r_wr_ptr] <= i_res;
        end
    end

endmodule

FILE: rtl/imrw_seq.sv
`include "i2c_master_register_write_defines.svh"

module imrw_seq
    import imrw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    input  t_cfg_idx   i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_avail,
    input  t_item      i_item,
    output logic       o_take,
    input  logic       i_out_full,
    output logic       o_put,
    output t_res       o_res
);

    logic [7:0] r_half, r_poll_limit;
    t_phase     r_phase, a_phase, n_phase;
    logic [8:0] r_tick, a_tick, n_tick;
    logic [2:0] r_bcnt, a_bcnt, n_bcnt;
    logic [1:0] r_bidx, a_bidx, n_bidx;
    logic [7:0] r_shift, a_shift, n_shift;
    logic [7:0] r_hreg, a_hreg;
    logic [7:0] r_hdat, a_hdat;
    logic [7:0] r_poll, n_poll;
    logic [2:0] r_ack, a_ack;
    logic       r_sticky, a_sticky;
    logic       s_step, s_done;
    logic [7:0] s_half;
    logic [8:0] s_len;
    logic [1:0] s_bnext;
    logic [2:0] s_ack_mask;

    assign s_step = i_in_avail && !i_out_full;
    assign o_take = s_step;
    assign o_put  = s_step;

    assign s_half = (r_half == 8'd0) ? 8'd1 : r_half;
    assign s_len  = (a_phase == PH_B0 || a_phase == PH_B2) ? {1'b0, s_half} : {s_half, 1'b0};

    // address byte sets bit 0, register byte bit 1, data byte bit 2
    assign s_ack_mask = a_bidx[0] ? 3'b010 : (a_bidx[1] ? 3'b100 : 3'b001);

    // Start a transaction and catch an acknowledge before the segment decode
    always_comb begin
        a_phase  = r_phase;
        a_tick   = r_tick;
        a_bcnt   = r_bcnt;
        a_bidx   = r_bidx;
        a_shift  = r_shift;
        a_hreg   = r_hreg;
        a_hdat   = r_hdat;
        a_ack    = r_ack;
        a_sticky = r_sticky;
        if (r_phase == PH_IDLE && i_item.request_valid) begin
            a_shift = {i_item.device_address, 1'b0};
            a_hreg  = i_item.register_address;
            a_hdat  = i_item.data_value;
            a_bidx  = 2'd0;
            a_bcnt  = 3'd0;
            a_ack   = 3'd0;
            a_phase = PH_S0;
            a_tick  = 9'd0;
        end
        if (a_phase == PH_POLL && a_tick == 9'd0 && !i_item.sda_level) begin
            a_ack    = r_ack | s_ack_mask;
            a_sticky = 1'b1;
            a_phase  = PH_AEND;
            a_tick   = 9'd0;
        end
    end

    // Next state
    always_comb begin
        n_phase = a_phase;
        n_tick  = a_tick;
        n_bcnt  = a_bcnt;
        n_bidx  = a_bidx;
        n_shift = a_shift;
        n_poll  = r_poll;
        s_done  = 1'b0;
        s_bnext = a_bidx + 2'd1;
        if (a_phase != PH_IDLE) begin
            if ({1'b0, a_tick} + 10'd1 >= {1'b0, s_len}) begin
                n_tick = 9'd0;
                unique case (a_phase)
                    PH_S0: n_phase = PH_S1;
                    PH_S1: n_phase = PH_S2;
                    PH_S2: n_phase = PH_S3;
                    PH_S3: begin
                        n_bcnt  = 3'd0;
                        n_phase = PH_B0;
                    end
                    PH_B0: n_phase = PH_B1;
                    PH_B1: n_phase = PH_B2;
                    PH_B2: begin
                        if (a_bcnt == 3'd7) begin
                            n_phase = PH_A0;
                        end else begin
                            n_bcnt  = a_bcnt + 3'd1;
                            n_shift = {a_shift[6:0], 1'b0};
                            n_phase = PH_B0;
                        end
                    end
                    PH_A0: n_phase = PH_A1;
                    PH_A1: begin
                        if (r_poll_limit == 8'd0) begin
                            n_phase = PH_AEND;
                        end else begin
                            n_poll  = r_poll_limit;
                            n_phase = PH_POLL;
                        end
                    end
                    PH_POLL: begin
                        if (r_poll <= 8'd1) begin
                            n_poll  = 8'd0;
                            n_phase = PH_AEND;
                        end else begin
                            n_poll = r_poll - 8'd1;
                        end
                    end
                    PH_AEND: begin
                        n_bidx = s_bnext;
                        if (s_bnext == 2'd3 || s_bnext == 2'd0) begin
                            n_phase = PH_P0;
                        end else begin
                            n_shift = (s_bnext == 2'd1) ? a_hreg : a_hdat;
                            n_bcnt  = 3'd0;
                            n_phase = PH_B0;
                        end
                    end
                    PH_P0: n_phase = PH_P1;
                    PH_P1: n_phase = PH_P2;
                    default: begin
                        s_done  = 1'b1;
                        n_bidx  = 2'd0;
                        n_phase = PH_IDLE;
                    end
                endcase
            end else begin
                n_tick = a_tick + 9'd1;
            end
        end
    end

    // Line levels and status fields for this tick
    always_comb begin
        o_res.scl_level    = 1'b1;
        o_res.sda_pull_low = 1'b0;
        unique case (a_phase)
            PH_S2: o_res.sda_pull_low = 1'b1;
            PH_S3: begin
                o_res.scl_level    = 1'b0;
                o_res.sda_pull_low = 1'b1;
            end
            PH_B0, PH_B2: begin
                o_res.scl_level    = 1'b0;
                o_res.sda_pull_low = !a_shift[MSB_BIT];
            end
            PH_B1:            o_res.sda_pull_low = !a_shift[MSB_BIT];
            PH_A0, PH_AEND:   o_res.scl_level    = 1'b0;
            PH_P0: begin
                o_res.scl_level    = 1'b0;
                o_res.sda_pull_low = 1'b1;
            end
            PH_P1:            o_res.sda_pull_low = 1'b1;
            default: begin
                o_res.scl_level    = 1'b1;
                o_res.sda_pull_low = 1'b0;
            end
        endcase
        o_res.busy_res     = (a_phase != PH_IDLE);
        o_res.done_res     = s_done;
        o_res.byte_acks    = a_ack;
        o_res.any_ack_seen = a_sticky;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half       <= HALF_BIT_TICKS_RESET;
            r_poll_limit <= ACK_POLL_LIMIT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_HALF_BIT_TICKS: r_half       <= i_cfg_data;
                default:            r_poll_limit <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_tick   <= 9'd0;
            r_bcnt   <= 3'd0;
            r_bidx   <= 2'd0;
            r_shift  <= 8'd0;
            r_hreg   <= 8'd0;
            r_hdat   <= 8'd0;
            r_poll   <= 8'd0;
            r_ack    <= 3'd0;
            r_sticky <= 1'b0;
        end else if (s_step) begin
            r_phase  <= n_phase;
            r_tick   <= n_tick;
            r_bcnt   <= n_bcnt;
            r_bidx   <= n_bidx;
            r_shift  <= n_shift;
            r_hreg   <= a_hreg;
            r_hdat   <= a_hdat;
            r_poll   <= n_poll;
            r_ack    <= a_ack;
            r_sticky <= a_sticky;
        end
    end

    `IMRW_ASSERT_NEXT(a_done_to_idle, s_step && s_done, r_phase == PH_IDLE,
        "sequencer not idle after STOP")
    `IMRW_ASSERT_NEXT(a_idle_holds, s_step && r_phase == PH_IDLE && !i_item.request_valid,
        r_phase == PH_IDLE, "sequencer left idle without a request")
    `IMRW_ASSERT_NEXT(a_sticky_holds, r_sticky, r_sticky, "ack flag cleared while running")
    `IMRW_ASSERT_NOW(a_done_busy, s_step && s_done, o_res.busy_res,
        "done tick reported as not busy")

endmodule

FILE: rtl/i2c_master_register_write.sv
// Register write master for a two-wire bus, one bus tick per request.
// Input queue: present one tick (request fields plus sampled SDA) with push
// while full is low. Each tick yields exactly one result (SCL level, SDA
// pull, busy, done pulse, per-byte acks, sticky ack flag), read from the
// result queue with pop while empty is low.
// A tick with request_valid while the sequencer is idle starts START, three
// bytes with acknowledge polling, then STOP; requests while busy are dropped.
// Configuration: write i_cfg_index/i_cfg_data with i_cfg_valid; o_cfg_ready
// is always high. Index 0 sets half_bit_ticks, index 1 ack_poll_limit.
// Write configuration only while the queues are drained.
// Path: a pushed tick is registered in the input queue; the sequencer step then
// writes its result into the result queue, whose output shows it until it is
// popped; the step waits while the result queue is full.
// Throughput: one tick per cycle while the result queue is not full.
// When pop is held low the result queue fills, the sequencer stalls, and
// full rises once the two-entry input queue is also full; nothing is lost.
// Reset: both queues empty, sequencer idle, acks clear, configuration back
// to half_bit_ticks 5 and ack_poll_limit 20.
module i2c_master_register_write
    import imrw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic       i_request_valid,
    input  logic [6:0] i_device_address,
    input  logic [7:0] i_register_address,
    input  logic [7:0] i_data_value,
    input  logic       i_sda_level,
    output logic       empty,
    input  logic       pop,
    output logic       o_scl_level,
    output logic       o_sda_pull_low,
    output logic       o_busy_res,
    output logic       o_done_res,
    output logic [2:0] o_byte_acks,
    output logic       o_any_ack_seen,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [0:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    t_item s_in_item, s_q_item;
    t_res  s_seq_res, s_out_res;
    t_link s_in_link;
    logic  s_put, s_out_full;

    assign s_in_item.request_valid    = i_request_valid;
    assign s_in_item.device_address   = i_device_address;
    assign s_in_item.register_address = i_register_address;
    assign s_in_item.data_value       = i_data_value;
    assign s_in_item.sda_level        = i_sda_level;

    assign o_cfg_ready = 1'b1;

    imrw_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (s_in_item),
        .o_full  (full),
        .i_take  (s_in_link.take),
        .o_avail (s_in_link.avail),
        .o_item  (s_q_item)
    );

    imrw_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (t_cfg_idx'(i_cfg_index)),
        .i_cfg_data  (i_cfg_data),
        .i_in_avail  (s_in_link.avail),
        .i_item      (s_q_item),
        .o_take      (s_in_link.take),
        .i_out_full  (s_out_full),
        .o_put       (s_put),
        .o_res       (s_seq_res)
    );

    imrw_res_queue u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_put   (s_put),
        .i_res   (s_seq_res),
        .o_full  (s_out_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_res   (s_out_res)
    );

    assign o_scl_level    = s_out_res.scl_level;
    assign o_sda_pull_low = s_out_res.sda_pull_low;
    assign o_busy_res     = s_out_res.busy_res;
    assign o_done_res     = s_out_res.done_res;
    assign o_byte_acks    = s_out_res.byte_acks;
    assign o_any_ack_seen = s_out_res.any_ack_seen;

endmodule

FILE: sim/tb_i2c_master_register_write.sv
module tb_i2c_master_register_write;
    timeunit 1ns;
    timeprecision 1ps;

    import imrw_pkg::*;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic       i_request_valid = 1'b0;
    logic [6:0] i_device_address = '0;
    logic [7:0] i_register_address = '0;
    logic [7:0] i_data_value = '0;
    logic       i_sda_level = 1'b1;
    logic       empty;
    logic       pop = 1'b0;
    logic       o_scl_level;
    logic       o_sda_pull_low;
    logic       o_busy_res;
    logic       o_done_res;
    logic [2:0] o_byte_acks;
    logic       o_any_ack_seen;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [0:0] i_cfg_index = '0;
    logic [7:0] i_cfg_data = '0;

    i2c_master_register_write uut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Bus sequencer mirror: configuration and state after every accepted tick
    logic [7:0] half_ticks = HALF_BIT_TICKS_RESET;
    logic [7:0] poll_limit = ACK_POLL_LIMIT_RESET;
    t_phase     ph = PH_IDLE;
    logic [8:0] tick_cnt = '0;
    logic [2:0] bit_cnt = '0;
    logic [1:0] byte_idx = '0;
    logic [7:0] shifter = '0;
    logic [7:0] reg_byte = '0;
    logic [7:0] data_byte = '0;
    logic [7:0] polls_left = '0;
    logic [2:0] acks = '0;
    logic       ack_seen = 1'b0;

    t_res expected_lines[$];
    t_res want;
    int   fail_count = 0;

    int          burst_left = 0;
    bit          push_on = 1'b0;
    bit          sender_steady = 1'b0;
    bit          stall_on = 1'b1;
    int          hold_left = 0;
    logic [15:0] stall_pat = 16'hFFFF;

    function automatic int seg_ticks(t_phase p);
        int h;
        h = (half_ticks == 8'd0) ? 1 : int'(half_ticks);
        return (p == PH_B0 || p == PH_B2) ? h : 2 * h;
    endfunction

    function automatic t_res predict_bus_tick(t_item it);
        t_res r;
        logic done;
        r = '0;
        r.scl_level = 1'b1;
        done = 1'b0;
        if (ph == PH_IDLE && it.request_valid) begin
            shifter   = {it.device_address, 1'b0};
            reg_byte  = it.register_address;
            data_byte = it.data_value;
            byte_idx  = '0;
            bit_cnt   = '0;
            acks      = '0;
            ph        = PH_S0;
            tick_cnt  = '0;
        end
        if (ph != PH_IDLE) begin
            // SDA low on the first tick of a poll interval ends the acknowledge at once
            if (ph == PH_POLL && tick_cnt == 9'd0 && !it.sda_level) begin
                acks[byte_idx[0] ? 1 : (byte_idx[1] ? 2 : 0)] = 1'b1;
                ack_seen = 1'b1;
                ph       = PH_AEND;
                tick_cnt = '0;
            end
            case (ph)
                PH_S0, PH_S1:   {r.scl_level, r.sda_pull_low} = 2'b10;
                PH_S2:          {r.scl_level, r.sda_pull_low} = 2'b11;
                PH_S3:          {r.scl_level, r.sda_pull_low} = 2'b01;
                PH_B0, PH_B2:   {r.scl_level, r.sda_pull_low} = {1'b0, !shifter[MSB_BIT]};
                PH_B1:          {r.scl_level, r.sda_pull_low} = {1'b1, !shifter[MSB_BIT]};
                PH_A0, PH_AEND: {r.scl_level, r.sda_pull_low} = 2'b00;
                PH_A1, PH_POLL: {r.scl_level, r.sda_pull_low} = 2'b10;
                PH_P0:          {r.scl_level, r.sda_pull_low} = 2'b01;
                PH_P1:          {r.scl_level, r.sda_pull_low} = 2'b11;
                default:        {r.scl_level, r.sda_pull_low} = 2'b10;
            endcase
            r.busy_res = 1'b1;
            if (int'(tick_cnt) + 1 >= seg_ticks(ph)) begin
                tick_cnt = '0;
                case (ph)
                    PH_S0: ph = PH_S1;
                    PH_S1: ph = PH_S2;
                    PH_S2: ph = PH_S3;
                    PH_S3: begin
                        bit_cnt = '0;
                        ph = PH_B0;
                    end
                    PH_B0: ph = PH_B1;
                    PH_B1: ph = PH_B2;
                    PH_B2: begin
                        if (bit_cnt == 3'd7) begin
                            ph = PH_A0;
                        end else begin
                            bit_cnt = bit_cnt + 3'd1;
                            shifter = shifter << 1;
                            ph = PH_B0;
                        end
                    end
                    PH_A0: ph = PH_A1;
                    PH_A1: begin
                        if (poll_limit == 8'd0) begin
                            ph = PH_AEND;
                        end else begin
                            polls_left = poll_limit;
                            ph = PH_POLL;
                        end
                    end
                    PH_POLL: begin
                        if (polls_left <= 8'd1) begin
                            polls_left = '0;
                            ph = PH_AEND;
                        end else begin
                            polls_left = polls_left - 8'd1;
                        end
                    end
                    PH_AEND: begin
                        byte_idx = byte_idx + 2'd1;
                        if (byte_idx == 2'd3 || byte_idx == 2'd0) begin
                            ph = PH_P0;
                        end else begin
                            shifter = (byte_idx == 2'd1) ? reg_byte : data_byte;
                            bit_cnt = '0;
                            ph = PH_B0;
                        end
                    end
                    PH_P0: ph = PH_P1;
                    PH_P1: ph = PH_P2;
                    default: begin
                        done = 1'b1;
                        byte_idx = '0;
                        ph = PH_IDLE;
                    end
                endcase
            end else begin
                tick_cnt = tick_cnt + 9'd1;
            end
        end
        r.done_res     = done;
        r.byte_acks    = acks;
        r.any_ack_seen = ack_seen;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            fail_count++;
        end
    endtask

    // Result side: compare against the oldest expectation, then pick the next pop
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (expected_lines.size() == 0) begin
                    $error("bus result popped with nothing expected");
                    fail_count++;
                end else begin
                    want = expected_lines.pop_front();
                    check_field("scl_level", 8'(want.scl_level), 8'(o_scl_level));
                    check_field("sda_pull_low", 8'(want.sda_pull_low), 8'(o_sda_pull_low));
                    check_field("busy_res", 8'(want.busy_res), 8'(o_busy_res));
                    check_field("done_res", 8'(want.done_res), 8'(o_done_res));
                    check_field("byte_acks", 8'(want.byte_acks), 8'(o_byte_acks));
                    check_field("any_ack_seen", 8'(want.any_ack_seen), 8'(o_any_ack_seen));
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (!stall_on) begin
                pop <= 1'b1;
            end else begin
                if ($urandom_range(0, 31) == 0)
                    stall_pat = 16'($urandom_range(1, 16'hFFFF));
                stall_pat = {stall_pat[14:0], stall_pat[15]};
                pop <= stall_pat[0];
            end
        end
    end

    task automatic send_tick(input t_item it);
        int gap;
        if (burst_left == 0 && !sender_steady) begin
            gap = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                if (push_on) begin
                    push <= 1'b0;
                    push_on = 1'b0;
                end
                repeat (gap) @(posedge i_clk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        push               <= 1'b1;
        push_on            = 1'b1;
        i_request_valid    <= it.request_valid;
        i_device_address   <= it.device_address;
        i_register_address <= it.register_address;
        i_data_value       <= it.data_value;
        i_sda_level        <= it.sda_level;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        expected_lines.push_back(predict_bus_tick(it));
    endtask

    task automatic sender_rest();
        if (push_on) begin
            push <= 1'b0;
            push_on = 1'b0;
            @(posedge i_clk);
        end
        burst_left = 0;
    endtask

    task automatic tick(input bit req, input bit sda);
        t_item it;
        it.request_valid    = req;
        it.device_address   = 7'($urandom_range(0, 127));
        it.register_address = 8'($urandom_range(0, 255));
        it.data_value       = 8'($urandom_range(0, 255));
        it.sda_level        = sda;
        send_tick(it);
    endtask

    task automatic run_ticks(input int n, input int req_pct, input int low_pct);
        repeat (n) tick($urandom_range(0, 99) < req_pct, $urandom_range(0, 99) >= low_pct);
    endtask

    // Idle ticks until the transfer in flight has sent its STOP
    task automatic finish_transfer(input int low_pct);
        while (ph != PH_IDLE) tick(1'b0, $urandom_range(0, 99) >= low_pct);
    endtask

    task automatic write_cfg(input t_cfg_idx idx, input logic [7:0] value);
        sender_rest();
        while (expected_lines.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_HALF_BIT_TICKS)
            half_ticks = value;
        else
            poll_limit = value;
    endtask

    task automatic test_reset_config();
        run_ticks(4, 0, 50);
        send_tick(t_item'{1'b1, 7'h2A, 8'h5A, 8'hC3, 1'b1});
        // START begins on the reset bit time, the bytes run on a short one
        run_ticks(24, 0, 50);
        write_cfg(CFG_HALF_BIT_TICKS, 8'd1);
        finish_transfer(15);
    endtask

    task automatic test_requests_while_busy();
        write_cfg(CFG_HALF_BIT_TICKS, 8'd1);
        send_tick(t_item'{1'b1, 7'h55, 8'hA5, 8'h3C, 1'b1});
        // keep requesting through the done tick; the one after it must start anew
        while (ph != PH_IDLE) tick(1'b1, 1'($urandom_range(0, 1)));
        tick(1'b1, 1'b1);
    endtask

    task automatic test_no_poll();
        // the transfer left open above runs on without poll intervals
        write_cfg(CFG_ACK_POLL_LIMIT, 8'd0);
        finish_transfer(100);
    endtask

    task automatic test_config_extremes();
        write_cfg(CFG_HALF_BIT_TICKS, 8'd255);
        write_cfg(CFG_ACK_POLL_LIMIT, 8'd255);
        send_tick(t_item'{1'b1, 7'h7F, 8'h00, 8'hFF, 1'b1});
        run_ticks(20, 0, 5);
        // zero half-bit count runs as one tick, in the middle of the START
        write_cfg(CFG_HALF_BIT_TICKS, 8'd0);
        finish_transfer(50);
    endtask

    task automatic test_backpressure();
        write_cfg(CFG_ACK_POLL_LIMIT, 8'd3);
        send_tick(t_item'{1'b1, 7'h12, 8'h34, 8'h56, 1'b1});
        sender_steady = 1'b1;
        hold_left = 80;
        run_ticks(40, 10, 40);
        sender_steady = 1'b0;
    endtask

    task automatic test_random_traffic();
        int low_pct;
        for (int round = 0; round < 2; round++) begin
            write_cfg(CFG_HALF_BIT_TICKS, 8'($urandom_range(0, 1)));
            write_cfg(CFG_ACK_POLL_LIMIT, 8'($urandom_range(0, 4)));
            low_pct = $urandom_range(0, 100);
            stall_on = round[0];
            sender_steady = (round == 1);
            run_ticks(30, 15, low_pct);
            finish_transfer(low_pct);
        end
        sender_steady = 1'b0;
        stall_on = 1'b1;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_config();
        test_requests_while_busy();
        test_no_poll();
        test_config_extremes();
        test_backpressure();
        test_random_traffic();
        sender_rest();
        stall_on = 1'b0;
        while (expected_lines.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("i2c_master_register_write: match");
        else
            $display("i2c_master_register_write: mismatch");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("i2c_master_register_write: mismatch");
        $finish;
    end

endmodule
